[rtl/core/drt_pkg.sv]
// shared types, operation codes and default sizes of the dirty rectangle tracker
`default_nettype none

package drt_pkg;

   localparam int DEF_SCREEN_WIDTH  = 640;
   localparam int DEF_SCREEN_HEIGHT = 480;
   localparam int DEF_MAX_RECTS     = 8;

   typedef logic [1:0] op_type;

   localparam op_type OP_MARK  = 2'd0;
   localparam op_type OP_READ  = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   // positions of the corners inside one stored box
   localparam logic [1:0] BOX_X0 = 2'd0;
   localparam logic [1:0] BOX_Y0 = 2'd1;
   localparam logic [1:0] BOX_X1 = 2'd2;
   localparam logic [1:0] BOX_Y1 = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

endpackage

`default_nettype wire

[rtl/core/dirty_rectangle_tracker_core.sv]
// dirty rectangle tracker: clip, merge-or-append scan over a box memory, read and clear
// read, clear and dropped marks go straight to the done state, which sets rsp_valid once the rsp register is free
// a mark scans one stored box per cycle through the memory read port;
// a full list folds into entry 0 during that same scan
// the next req transfer waits in the done state for the rsp register
// reset (synchronous) empties the list and the rsp register; box memory is not cleared
`default_nettype none

module dirty_rectangle_tracker_core #(
   parameter int SCREEN_WIDTH  = drt_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = drt_pkg::DEF_SCREEN_HEIGHT,
   parameter int MAX_RECTS     = drt_pkg::DEF_MAX_RECTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  drt_pkg::op_type      req_operation,
   input  logic signed [15:0]   req_rect_x,
   input  logic signed [15:0]   req_rect_y,
   input  logic signed [15:0]   req_rect_w,
   input  logic signed [15:0]   req_rect_h,
   input  logic [2:0]           req_entry_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [9:0]           rsp_entry_x,
   output logic [8:0]           rsp_entry_y,
   output logic [9:0]           rsp_entry_w,
   output logic [8:0]           rsp_entry_h,
   output logic                 rsp_entry_valid,
   output logic [3:0]           rsp_list_count
);
   import drt_pkg::*;

   localparam int CW   = $clog2(((SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH
                                                                : SCREEN_HEIGHT) + 1);
   localparam int AW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNTW = $clog2(MAX_RECTS + 1);
   localparam int VW   = (CNTW > 3) ? CNTW : 3;

   localparam logic signed [17:0] SW_S  = 18'(SCREEN_WIDTH);
   localparam logic signed [17:0] SH_S  = 18'(SCREEN_HEIGHT);
   localparam logic [CNTW-1:0]    MAX_C = CNTW'(MAX_RECTS);
   localparam logic [CNTW-1:0]    ONE_C = CNTW'(1);

   typedef logic [3:0][CW-1:0] box_type;

   function automatic logic boxes_meet(input box_type a, input box_type b);
      return (a[BOX_X0] <= b[BOX_X1]) && (b[BOX_X0] <= a[BOX_X1]) &&
             (a[BOX_Y0] <= b[BOX_Y1]) && (b[BOX_Y0] <= a[BOX_Y1]);
   endfunction

   function automatic box_type bound_of(input box_type a, input box_type b);
      box_type r;
      r[BOX_X0] = (a[BOX_X0] < b[BOX_X0]) ? a[BOX_X0] : b[BOX_X0];
      r[BOX_Y0] = (a[BOX_Y0] < b[BOX_Y0]) ? a[BOX_Y0] : b[BOX_Y0];
      r[BOX_X1] = (a[BOX_X1] > b[BOX_X1]) ? a[BOX_X1] : b[BOX_X1];
      r[BOX_Y1] = (a[BOX_Y1] > b[BOX_Y1]) ? a[BOX_Y1] : b[BOX_Y1];
      return r;
   endfunction

   state_type        state_ff, state_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   box_type          rect_ff, rect_in;
   box_type          acc_ff, acc_in;
   op_type           op_ff, op_in;
   logic             hit_ff, hit_in;

   box_type          mem [MAX_RECTS];
   box_type          rd_data_ff;
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   box_type          mem_wdata;

   logic             rsp_valid_ff;
   logic [9:0]       entry_x_ff, entry_w_ff;
   logic [8:0]       entry_y_ff, entry_h_ff;
   logic             entry_valid_ff;
   logic [3:0]       list_count_ff;

   logic             accept, done_go;

   // clipping
   logic signed [17:0] xs, ys, ws, hs, x1s, y1s, x0c, y0c, x1c, y1c;
   logic               clip_ok;
   box_type            clip_box;

   // read index
   logic [VW-1:0]      idx_v;
   logic               rd_hit;
   logic [AW-1:0]      rd_addr;

   // scan step
   logic [CNTW-1:0]    nxt;
   logic               meets;
   logic [CW-1:0]      diff_w, diff_h;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign done_go   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      xs  = 18'(req_rect_x);
      ys  = 18'(req_rect_y);
      ws  = 18'(req_rect_w);
      hs  = 18'(req_rect_h);
      x1s = xs + ws;
      y1s = ys + hs;
      x0c = (xs < 18'sd0) ? 18'sd0 : xs;
      y0c = (ys < 18'sd0) ? 18'sd0 : ys;
      x1c = (x1s > SW_S) ? SW_S : x1s;
      y1c = (y1s > SH_S) ? SH_S : y1s;
      clip_ok = (ws > 18'sd0) && (hs > 18'sd0) && (x0c < x1c) && (y0c < y1c);
      clip_box[BOX_X0] = x0c[CW-1:0];
      clip_box[BOX_Y0] = y0c[CW-1:0];
      clip_box[BOX_X1] = x1c[CW-1:0];
      clip_box[BOX_Y1] = y1c[CW-1:0];
   end

   always_comb begin
      idx_v   = VW'(req_entry_index);
      rd_hit  = (idx_v < VW'(count_ff)) && (idx_v < VW'(MAX_RECTS));
      rd_addr = idx_v[AW-1:0];
   end

   assign nxt    = CNTW'(ptr_ff) + ONE_C;
   assign meets  = boxes_meet(rd_data_ff, rect_ff);
   assign diff_w = rd_data_ff[BOX_X1] - rd_data_ff[BOX_X0];
   assign diff_h = rd_data_ff[BOX_Y1] - rd_data_ff[BOX_Y0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      rect_in   = rect_ff;
      acc_in    = acc_ff;
      op_in     = op_ff;
      hit_in    = hit_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = clip_box;
      mem_re    = 1'b0;
      mem_raddr = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               rect_in  = clip_box;
               acc_in   = clip_box;
               ptr_in   = '0;
               hit_in   = rd_hit;
               state_in = S_DONE;
               case (req_operation)
                  OP_MARK: begin
                     if (clip_ok) begin
                        if (count_ff == '0) begin
                           mem_we   = 1'b1;
                           count_in = ONE_C;
                        end else begin
                           mem_re   = 1'b1;
                           state_in = S_SCAN;
                        end
                     end
                  end
                  OP_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = rd_addr;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            acc_in = bound_of(acc_ff, rd_data_ff);
            if (meets) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff;
               mem_wdata = bound_of(rd_data_ff, rect_ff);
               state_in  = S_DONE;
            end else if (nxt < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = nxt[AW-1:0];
               ptr_in    = nxt[AW-1:0];
            end else if (count_ff < MAX_C) begin
               mem_we    = 1'b1;
               mem_waddr = count_ff[AW-1:0];
               mem_wdata = rect_ff;
               count_in  = count_ff + ONE_C;
               state_in  = S_DONE;
            end else begin
               // list full: everything folds into entry 0
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = bound_of(acc_ff, rd_data_ff);
               count_in  = ONE_C;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (done_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      rect_ff <= rect_in;
      acc_ff  <= acc_in;
      op_ff   <= op_in;
      hit_ff  <= hit_in;
      if (done_go) begin
         list_count_ff <= 4'(count_ff);
         if ((op_ff == OP_READ) && hit_ff) begin
            entry_x_ff     <= 10'(rd_data_ff[BOX_X0]);
            entry_y_ff     <= 9'(rd_data_ff[BOX_Y0]);
            entry_w_ff     <= 10'(diff_w);
            entry_h_ff     <= 9'(diff_h);
            entry_valid_ff <= 1'b1;
         end else begin
            entry_x_ff     <= '0;
            entry_y_ff     <= '0;
            entry_w_ff     <= '0;
            entry_h_ff     <= '0;
            entry_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_x     = entry_x_ff;
   assign rsp_entry_y     = entry_y_ff;
   assign rsp_entry_w     = entry_w_ff;
   assign rsp_entry_h     = entry_h_ff;
   assign rsp_entry_valid = entry_valid_ff;
   assign rsp_list_count  = list_count_ff;

endmodule

`default_nettype wire

[sim/dirty_rectangle_tracker_core_tb.sv]
// self-checking testbench for the dirty rectangle tracker core with a built-in list predictor
`timescale 1ns / 1ps

module dirty_rectangle_tracker_core_tb;
   import drt_pkg::*;

   localparam op_type OP_SPARE      = 2'd3;
   localparam int     SCR_W         = 640;
   localparam int     SCR_H         = 480;
   localparam int     LIST_DEPTH    = 8;
   localparam int     RANDOM_ITEMS  = 382;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     DRAIN_CYCLES  = 24;
   localparam int     QUIET_LIMIT   = 4000;

   typedef struct {
      op_type             op;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
      logic [2:0]         idx;
   } dirty_req_type;

   typedef struct {
      logic [9:0] x;
      logic [8:0] y;
      logic [9:0] w;
      logic [8:0] h;
      logic       valid;
      logic [3:0] count;
   } entry_rsp_type;

   typedef struct {
      int x;
      int y;
      int w;
      int h;
   } box_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   op_type             req_operation = OP_MARK;
   logic signed [15:0] req_rect_x = '0;
   logic signed [15:0] req_rect_y = '0;
   logic signed [15:0] req_rect_w = '0;
   logic signed [15:0] req_rect_h = '0;
   logic [2:0]         req_entry_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [9:0]         rsp_entry_x;
   logic [8:0]         rsp_entry_y;
   logic [9:0]         rsp_entry_w;
   logic [8:0]         rsp_entry_h;
   logic               rsp_entry_valid;
   logic [3:0]         rsp_list_count;

   dirty_req_type pend_q[$];
   entry_rsp_type answer_q[$];
   entry_rsp_type want;

   box_type dirty_list[LIST_DEPTH];
   int      dirty_total = 0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_armed = 1'b0;
   bit hold_done;
   int hold_left;
   int quiet_cycles;
   int error_count = 0;

   dirty_rectangle_tracker_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_x     (rsp_entry_x),
      .rsp_entry_y     (rsp_entry_y),
      .rsp_entry_w     (rsp_entry_w),
      .rsp_entry_h     (rsp_entry_h),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_list_count  (rsp_list_count)
   );

   always #10 clock = ~clock;

   function automatic bit boxes_touch(box_type a, box_type b);
      return a.x <= b.x + b.w && b.x <= a.x + a.w &&
             a.y <= b.y + b.h && b.y <= a.y + a.h;
   endfunction

   function automatic box_type box_union(box_type a, box_type b);
      box_type u;
      int      ax1, ay1, bx1, by1;
      ax1 = a.x + a.w;
      ay1 = a.y + a.h;
      bx1 = b.x + b.w;
      by1 = b.y + b.h;
      u.x = (a.x < b.x) ? a.x : b.x;
      u.y = (a.y < b.y) ? a.y : b.y;
      u.w = ((ax1 > bx1) ? ax1 : bx1) - u.x;
      u.h = ((ay1 > by1) ? ay1 : by1) - u.y;
      return u;
   endfunction

   function automatic void mark_dirty(int x, int y, int w, int h);
      box_type r;
      int      x0, y0, x1, y1;
      if (w <= 0 || h <= 0) return;
      x0 = (x < 0) ? 0 : x;
      y0 = (y < 0) ? 0 : y;
      x1 = (x + w > SCR_W) ? SCR_W : x + w;
      y1 = (y + h > SCR_H) ? SCR_H : y + h;
      if (x0 >= x1 || y0 >= y1) return;
      r = '{x0, y0, x1 - x0, y1 - y0};
      for (int i = 0; i < dirty_total; i++) begin
         if (boxes_touch(dirty_list[i], r)) begin
            dirty_list[i] = box_union(dirty_list[i], r);
            return;
         end
      end
      if (dirty_total < LIST_DEPTH) begin
         dirty_list[dirty_total] = r;
         dirty_total++;
         return;
      end
      for (int i = 0; i < dirty_total; i++) r = box_union(r, dirty_list[i]);
      dirty_list[0] = r;
      dirty_total = 1;
   endfunction

   function automatic entry_rsp_type track_request(dirty_req_type it);
      entry_rsp_type a;
      a = '{default: '0};
      case (it.op)
         OP_MARK:  mark_dirty(int'(it.x), int'(it.y), int'(it.w), int'(it.h));
         OP_READ: begin
            if (int'(it.idx) < dirty_total) begin
               a.x     = 10'(dirty_list[it.idx].x);
               a.y     = 9'(dirty_list[it.idx].y);
               a.w     = 10'(dirty_list[it.idx].w);
               a.h     = 9'(dirty_list[it.idx].h);
               a.valid = 1'b1;
            end
         end
         OP_CLEAR: dirty_total = 0;
         default: ;
      endcase
      a.count = 4'(dirty_total);
      return a;
   endfunction

   task automatic add_item(op_type op, int x, int y, int w, int h, int idx);
      dirty_req_type it;
      it.op  = op;
      it.x   = 16'(x);
      it.y   = 16'(y);
      it.w   = 16'(w);
      it.h   = 16'(h);
      it.idx = 3'(idx);
      pend_q.push_back(it);
   endtask

   task automatic add_random_item();
      int r;
      r = $urandom_range(99);
      if (r < 50) begin
         add_item(OP_MARK, $urandom_range(679) - 20, $urandom_range(519) - 20,
                  $urandom_range(1, 48), $urandom_range(1, 48), $urandom_range(7));
      end else if (r < 55) begin
         add_item(OP_MARK, $urandom, $urandom, -int'($urandom_range(32768)),
                  $urandom, $urandom_range(7));
      end else if (r < 62) begin
         add_item(OP_MARK, $urandom, $urandom, $urandom, $urandom, $urandom_range(7));
      end else if (r < 93) begin
         add_item(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom_range(7));
      end else if (r < 97) begin
         add_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom_range(7));
      end else begin
         add_item(OP_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom_range(7));
      end
   endtask

   task automatic wait_drained();
      while (pend_q.size() != 0 || answer_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) answer_q.push_back(track_request(pend_q.pop_front()));
         if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_operation   <= pend_q[0].op;
            req_rect_x      <= pend_q[0].x;
            req_rect_y      <= pend_q[0].y;
            req_rect_w      <= pend_q[0].w;
            req_rect_h      <= pend_q[0].h;
            req_entry_index <= pend_q[0].idx;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side backpressure, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_q.size() == 0) begin
            $error("unexpected response transfer");
            error_count++;
         end else begin
            want = answer_q.pop_front();
            check_field("entry_x", want.x, rsp_entry_x);
            check_field("entry_y", want.y, rsp_entry_y);
            check_field("entry_w", want.w, rsp_entry_w);
            check_field("entry_h", want.h, rsp_entry_h);
            check_field("entry_valid", want.valid, rsp_entry_valid);
            check_field("list_count", want.count, rsp_list_count);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("dirty_rectangle_tracker_core_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_item(OP_READ, 0, 0, 0, 0, 0);
      add_item(OP_MARK, 10, 10, 0, 10, 0);
      add_item(OP_MARK, 10, 10, 10, -5, 0);
      add_item(OP_MARK, 700, 10, 10, 10, 0);
      add_item(OP_MARK, -32768, -32768, 32767, 32767, 0);
      add_item(OP_MARK, -10, -10, 20, 20, 0);
      add_item(OP_MARK, 10, 10, 5, 5, 0);
      add_item(OP_MARK, 100, 100, 10, 10, 0);
      add_item(OP_MARK, 620, 470, 32767, 32767, 0);
      add_item(OP_MARK, 200, 0, 5, 5, 0);
      add_item(OP_MARK, 300, 0, 5, 5, 0);
      add_item(OP_MARK, 400, 0, 5, 5, 0);
      add_item(OP_MARK, 0, 300, 5, 5, 0);
      add_item(OP_MARK, 200, 300, 5, 5, 0);
      add_item(OP_READ, 0, 0, 0, 0, 7);
      add_item(OP_MARK, 500, 200, 5, 5, 0);
      add_item(OP_READ, 0, 0, 0, 0, 0);
      add_item(OP_READ, 0, 0, 0, 0, 1);
      add_item(OP_SPARE, 5, 5, 5, 5, 0);
      add_item(OP_MARK, 0, 0, 32767, 32767, 0);
      add_item(OP_READ, 0, 0, 0, 0, 0);
      add_item(OP_CLEAR, 0, 0, 0, 0, 0);
      add_item(OP_READ, 0, 0, 0, 0, 0);
      add_item(OP_MARK, 32767, 32767, 32767, 32767, 0);

      // no idling, with one long receiver hold-off
      hold_armed = 1'b1;
      repeat (RANDOM_ITEMS) add_random_item();
      wait_drained();

      send_idle_pct = 45;
      stall_pct     = 0;
      repeat (RANDOM_ITEMS) add_random_item();
      wait_drained();

      send_idle_pct = 0;
      stall_pct     = 45;
      repeat (RANDOM_ITEMS) add_random_item();
      wait_drained();

      send_idle_pct = 16;
      stall_pct     = 16;
      repeat (RANDOM_ITEMS) add_random_item();
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("dirty_rectangle_tracker_core_tb: done, clean");
      end else begin
         $display("dirty_rectangle_tracker_core_tb: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/drt_pkg.sv
rtl/core/dirty_rectangle_tracker_core.sv
sim/dirty_rectangle_tracker_core_tb.sv
